[design/msd_pkg.sv]
// Shared constants, types and helpers for the sorted multiset block.
package msd_pkg;

    localparam int CAPACITY = 64;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HALTED    = 3'd4;

    typedef enum logic [1:0] {
        K_ADD,
        K_REMOVE,
        K_FINISH,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [STATUS_W-1:0]     status;
        logic                    last;
    } res_t;

    // Flip the sign bit so that unsigned order equals signed order.
    function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] raw);
        return raw ^ {1'b1, {(VAL_W-1){1'b0}}};
    endfunction

endpackage

[design/msd_front.sv]
// Front end: command queue that accepts and decodes incoming transactions.
module msd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [msd_pkg::OP_W-1:0]            op,
    input  logic signed [msd_pkg::VAL_W-1:0]    value,
    output logic                                cmd_valid,
    output msd_pkg::cmd_t                       cmd,
    input  logic                                cmd_take
);

    msd_pkg::cmd_t                     q_reg [msd_pkg::CMDQ_DEPTH];
    logic [msd_pkg::CMDQ_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [msd_pkg::CMDQ_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [msd_pkg::CMDQ_CNT_W-1:0]    cnt_reg, cnt_next;
    msd_pkg::cmd_t                     dec_cmd;
    logic                              wr_en;
    logic                              rd_en;

    // Decode the op field into a command kind.
    always_comb
    begin
        dec_cmd.value = value;
        unique case (op)
            msd_pkg::OP_ADD:    dec_cmd.kind = msd_pkg::K_ADD;
            msd_pkg::OP_REMOVE: dec_cmd.kind = msd_pkg::K_REMOVE;
            msd_pkg::OP_FINISH: dec_cmd.kind = msd_pkg::K_FINISH;
            default:            dec_cmd.kind = msd_pkg::K_NOP;
        endcase
    end

    assign full      = (cnt_reg == msd_pkg::CMDQ_CNT_W'(msd_pkg::CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

endmodule

[design/msd_back.sv]
// Back end: sorted cell chain with insert, delete-on-match and shift-out drain.
module msd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  msd_pkg::cmd_t    cmd,
    output logic             cmd_take,
    input  logic             res_space,
    output logic             res_push,
    output msd_pkg::res_t    res
);

    typedef enum logic {
        S_CMD,
        S_DRAIN
    } state_t;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_INSERT,
        SH_REMOVE,
        SH_DRAIN
    } shift_t;

    localparam logic [msd_pkg::CAPACITY-1:0] ALL_ONES = '1;

    logic [msd_pkg::VAL_W-1:0]   cell_reg  [msd_pkg::CAPACITY];
    logic [msd_pkg::VAL_W-1:0]   cell_next [msd_pkg::CAPACITY];
    logic [msd_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        halted_reg, halted_next;
    state_t                      state_reg, state_next;
    shift_t                      shift_sel;
    logic [msd_pkg::CAPACITY-1:0] le_vec;
    logic [msd_pkg::CAPACITY-1:0] match_vec;
    logic [msd_pkg::CAPACITY-1:0] seen_vec;
    logic                        found;
    logic                        is_full;
    logic                        is_empty;

    // Per-cell compare against the command operand.
    always_comb
    begin
        for (int i = 0; i < msd_pkg::CAPACITY; i++)
        begin
            le_vec[i]    = (msd_pkg::CNT_W'(i) < count_reg) &&
                           (msd_pkg::order_key(cell_reg[i]) <= msd_pkg::order_key(cmd.value));
            match_vec[i] = (msd_pkg::CNT_W'(i) < count_reg) && (cell_reg[i] == cmd.value);
        end
        for (int i = 0; i < msd_pkg::CAPACITY; i++)
        begin
            seen_vec[i] = |(match_vec & (ALL_ONES >> (msd_pkg::CAPACITY - 1 - i)));
        end
    end

    assign found    = |match_vec;
    assign is_full  = (count_reg == msd_pkg::CNT_W'(msd_pkg::CAPACITY));
    assign is_empty = (count_reg == '0);

    // Controller: take one command, or emit one drained value, per cycle while the result queue has space.
    always_comb
    begin
        cmd_take    = 1'b0;
        res_push    = 1'b0;
        res         = '0;
        shift_sel   = SH_HOLD;
        count_next  = count_reg;
        halted_next = halted_reg;
        state_next  = state_reg;
        unique case (state_reg)
            S_CMD:
            begin
                if (cmd_valid && res_space)
                begin
                    cmd_take = 1'b1;
                    if (halted_reg)
                    begin
                        res_push   = 1'b1;
                        res.status = msd_pkg::ST_HALTED;
                        res.last   = 1'b1;
                    end
                    else
                    begin
                        unique case (cmd.kind)
                            msd_pkg::K_ADD:
                            begin
                                if (is_full)
                                begin
                                    res_push   = 1'b1;
                                    res.status = msd_pkg::ST_FULL;
                                    res.last   = 1'b1;
                                end
                                else
                                begin
                                    shift_sel  = SH_INSERT;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            msd_pkg::K_REMOVE:
                            begin
                                if (found)
                                begin
                                    shift_sel  = SH_REMOVE;
                                    count_next = count_reg - 1'b1;
                                end
                                else
                                begin
                                    halted_next = 1'b1;
                                    res_push    = 1'b1;
                                    res.status  = msd_pkg::ST_NOT_FOUND;
                                    res.last    = 1'b1;
                                end
                            end
                            msd_pkg::K_FINISH:
                            begin
                                if (is_empty)
                                begin
                                    res_push   = 1'b1;
                                    res.status = msd_pkg::ST_EMPTY;
                                    res.last   = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_DRAIN;
                                end
                            end
                            default:
                            begin
                                // Unused op code: drop it.
                            end
                        endcase
                    end
                end
            end
            S_DRAIN:
            begin
                if (res_space)
                begin
                    res_push   = 1'b1;
                    res.value  = cell_reg[0];
                    res.status = msd_pkg::ST_OK;
                    res.last   = (count_reg == msd_pkg::CNT_W'(1));
                    shift_sel  = SH_DRAIN;
                    count_next = count_reg - 1'b1;
                    if (count_reg == msd_pkg::CNT_W'(1))
                    begin
                        state_next = S_CMD;
                    end
                end
            end
            default:
            begin
                state_next = S_CMD;
            end
        endcase
    end

    // Next value of every cell in the chain.
    always_comb
    begin
        for (int i = 0; i < msd_pkg::CAPACITY; i++)
        begin
            case (shift_sel)
                SH_INSERT:
                begin
                    if (le_vec[i])
                    begin
                        cell_next[i] = cell_reg[i];
                    end
                    else if (i == 0)
                    begin
                        cell_next[i] = cmd.value;
                    end
                    else if (le_vec[(i == 0) ? 0 : i - 1])
                    begin
                        cell_next[i] = cmd.value;
                    end
                    else
                    begin
                        cell_next[i] = cell_reg[(i == 0) ? 0 : i - 1];
                    end
                end
                SH_REMOVE, SH_DRAIN:
                begin
                    if ((shift_sel == SH_DRAIN || seen_vec[i]) && i < msd_pkg::CAPACITY - 1)
                    begin
                        cell_next[i] = cell_reg[(i < msd_pkg::CAPACITY - 1) ? i + 1 : i];
                    end
                    else
                    begin
                        cell_next[i] = cell_reg[i];
                    end
                end
                default:
                begin
                    cell_next[i] = cell_reg[i];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CMD;
            count_reg  <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < msd_pkg::CAPACITY; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= msd_pkg::CNT_W'(msd_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAIN |-> count_reg != '0)
        else $error("drain with empty store");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt cleared without reset");

    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> res_space)
        else $error("result pushed into full queue");

    a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN && res_space) |=>
            count_reg == $past(count_reg) - msd_pkg::CNT_W'(1))
        else $error("drain did not advance");
`endif

endmodule

[design/msd_outq.sv]
// Result queue: holds finished result transactions until they are popped.
module msd_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_push,
    input  msd_pkg::res_t    res_in,
    output logic             res_space,
    output logic             empty,
    input  logic             pop,
    output msd_pkg::res_t    head
);

    msd_pkg::res_t                     q_reg [msd_pkg::OUTQ_DEPTH];
    logic [msd_pkg::OUTQ_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [msd_pkg::OUTQ_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [msd_pkg::OUTQ_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                              wr_en;
    logic                              rd_en;

    assign res_space = (cnt_reg != msd_pkg::OUTQ_CNT_W'(msd_pkg::OUTQ_DEPTH));
    assign empty     = (cnt_reg == '0);
    assign head      = q_reg[rd_ptr_reg];
    assign wr_en     = res_push && res_space;
    assign rd_en     = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

[design/multiset_table_sorted_drain_top.sv]
// Top level of the bounded sorted multiset with sorted drain.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-------------------------------------------------
//   command   | push / full        | op[1:0], value[31:0] signed
//   result    | empty / pop        | result_value[31:0] signed, status[2:0], last
//
// Add and remove retire one per cycle in the cell chain while the result queue
// has space, after the command queue registers them. Finish enters the drain
// state, then shifts one stored value out per cycle through cell 0 while there is space.
// Reset (rst_n, asynchronous, active low) empties both queues and clears the
// entry count and the halt flag; the cells themselves are not cleared.
// A stalled result side fills the result queue, holds the chain, then raises full.
module multiset_table_sorted_drain_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [msd_pkg::OP_W-1:0]            op,
    input  logic signed [msd_pkg::VAL_W-1:0]    value,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [msd_pkg::VAL_W-1:0]    result_value,
    output logic [msd_pkg::STATUS_W-1:0]        status,
    output logic                                last
);

    // Front to back: decoded command at the head of the command queue.
    logic             cmd_valid;
    msd_pkg::cmd_t    cmd;
    logic             cmd_take;

    // Back to result queue: one result transaction per cycle at most.
    logic             res_push;
    msd_pkg::res_t    res;
    logic             res_space;
    msd_pkg::res_t    head;

    // Accept and classify command transactions.
    msd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // Carry out commands on the sorted cell chain.
    msd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_space (res_space),
        .res_push  (res_push),
        .res       (res)
    );

    // Hold results until the consumer pops them.
    msd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res_in    (res),
        .res_space (res_space),
        .empty     (empty),
        .pop       (pop),
        .head      (head)
    );

    assign result_value = head.value;
    assign status       = head.status;
    assign last         = head.last;

endmodule

[tb/tb_multiset_table_sorted_drain_top.sv]
// Self-checking testbench for the sorted multiset with sorted drain.
`timescale 1ns / 100ps

module tb_multiset_table_sorted_drain_top;

    // Op code 3 has no meaning in the block; it must be dropped silently.
    localparam logic [msd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int VAL_MIN     = int'(32'h8000_0000);
    localparam int VAL_MAX     = int'(32'h7fff_ffff);
    localparam int IDLE_PCT    = 37;
    localparam int RANDOM_CMDS = 415;
    localparam int DRAIN_TAIL  = msd_pkg::CAPACITY + 16;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic [msd_pkg::OP_W-1:0]         op;
        logic signed [msd_pkg::VAL_W-1:0] val;
        bit                               hold;  // wait for every owed result first
    } command_t;

    typedef struct {
        logic signed [msd_pkg::VAL_W-1:0] rv;
        logic [msd_pkg::STATUS_W-1:0]     st;
        logic                             lst;
    } outcome_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             push = 1'b0;
    logic                             full;
    logic [msd_pkg::OP_W-1:0]         op = msd_pkg::OP_ADD;
    logic signed [msd_pkg::VAL_W-1:0] value = '0;
    logic                             empty;
    logic                             pop = 1'b0;
    logic signed [msd_pkg::VAL_W-1:0] result_value;
    logic [msd_pkg::STATUS_W-1:0]     status;
    logic                             last;

    multiset_table_sorted_drain_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .op           (op),
        .value        (value),
        .empty        (empty),
        .pop          (pop),
        .result_value (result_value),
        .status       (status),
        .last         (last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Commands waiting to be driven, and results the block still owes us.
    command_t command_q[$];
    outcome_t owed_results[$];

    // Shadow of the multiset, kept in ascending signed order.
    logic signed [msd_pkg::VAL_W-1:0] sorted_shadow[msd_pkg::CAPACITY];
    int                               shadow_count = 0;
    bit                               shadow_halted = 1'b0;

    // Generator-side view of what is stored, used to size the fills and to pick
    // removes that hit, so the block does not halt before the end of the run.
    int gen_pool[$];

    int cmds_accepted = 0;
    int adds_seen = 0;
    int removes_seen = 0;
    int finishes_seen = 0;
    int full_drops = 0;
    int halted_replies = 0;
    int results_checked = 0;
    int mismatches = 0;
    int stall_cycles = 0;
    command_t head_cmd;
    outcome_t want;
    logic calm;

    // Turn off idling on both sides for a stretch of the run.
    assign calm = (cmds_accepted >= 150) && (cmds_accepted < 260);

    function automatic void owe_result(input logic signed [msd_pkg::VAL_W-1:0] rv,
                                       input logic [msd_pkg::STATUS_W-1:0] st,
                                       input logic lst);
        outcome_t o;
        o.rv  = rv;
        o.st  = st;
        o.lst = lst;
        owed_results.insert(owed_results.size(), o);
    endfunction

    // Apply one accepted command to the shadow and queue the results it causes.
    task automatic predict_command(input logic [msd_pkg::OP_W-1:0] cmd_op,
                                   input logic signed [msd_pkg::VAL_W-1:0] cmd_val);
        int pos;
        int idx;
        if (shadow_halted)
        begin
            owe_result('0, msd_pkg::ST_HALTED, 1'b1);
            halted_replies++;
            return;
        end
        pos = 0;
        case (cmd_op)
            msd_pkg::OP_ADD:
            begin
                adds_seen++;
                if (shadow_count >= msd_pkg::CAPACITY)
                begin
                    owe_result('0, msd_pkg::ST_FULL, 1'b1);
                    full_drops++;
                end
                else
                begin
                    while (pos < shadow_count && sorted_shadow[pos] <= cmd_val)
                        pos++;
                    for (idx = shadow_count; idx > pos; idx--)
                        sorted_shadow[idx] = sorted_shadow[idx-1];
                    sorted_shadow[pos] = cmd_val;
                    shadow_count++;
                end
            end
            msd_pkg::OP_REMOVE:
            begin
                removes_seen++;
                while (pos < shadow_count && sorted_shadow[pos] != cmd_val)
                    pos++;
                if (pos >= shadow_count)
                begin
                    // No copy: the block reports it and refuses all later work.
                    shadow_halted = 1'b1;
                    owe_result('0, msd_pkg::ST_NOT_FOUND, 1'b1);
                end
                else
                begin
                    for (idx = pos; idx + 1 < shadow_count; idx++)
                        sorted_shadow[idx] = sorted_shadow[idx+1];
                    shadow_count--;
                end
            end
            msd_pkg::OP_FINISH:
            begin
                finishes_seen++;
                if (shadow_count == 0)
                    owe_result('0, msd_pkg::ST_EMPTY, 1'b1);
                else
                    for (idx = 0; idx < shadow_count; idx++)
                        owe_result(sorted_shadow[idx], msd_pkg::ST_OK,
                                   idx == shadow_count - 1);
                shadow_count = 0;
            end
            default: ;
        endcase
    endtask

    // Queue a command for the driver and track its effect on the generator pool.
    task automatic queue_cmd(input logic [msd_pkg::OP_W-1:0] c_op, input int c_val,
                             input bit c_hold);
        command_t c;
        int idx;
        c.op   = c_op;
        c.val  = c_val;
        c.hold = c_hold;
        command_q.insert(command_q.size(), c);
        idx = 0;
        case (c_op)
            msd_pkg::OP_ADD:
                if (gen_pool.size() < msd_pkg::CAPACITY)
                    gen_pool.insert(gen_pool.size(), c_val);
            msd_pkg::OP_REMOVE:
            begin
                while (idx < gen_pool.size() && gen_pool[idx] != c_val)
                    idx++;
                if (idx < gen_pool.size())
                    gen_pool.delete(idx);
            end
            msd_pkg::OP_FINISH:
                gen_pool.delete();
            default: ;
        endcase
    endtask

    // Favor a narrow band so duplicates are common; mix in extremes and full range.
    function automatic int pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return int'($urandom_range(0, 16)) - 8;
            4:
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return 0;
                    default: return -1;
                endcase
            default: return int'($urandom);
        endcase
    endfunction

    function automatic void check_field(input string field,
                                        input logic [msd_pkg::VAL_W-1:0] exp_v,
                                        input logic [msd_pkg::VAL_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Driver: present the head of the command queue, advance on each accepted
    // transaction, and idle at random outside the calm stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push  <= 1'b0;
            op    <= msd_pkg::OP_ADD;
            value <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_command(op, value);
                cmds_accepted++;
            end
            if (!push || !full)
            begin
                if (command_q.size() != 0
                    && !(command_q[0].hold && owed_results.size() != 0)
                    && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    head_cmd = command_q[0];
                    command_q.delete(0);
                    push  <= 1'b1;
                    op    <= head_cmd.op;
                    value <= head_cmd.val;
                end
                else
                begin
                    // Hold push low and scramble the payload; it must be ignored.
                    push  <= 1'b0;
                    value <= $urandom;
                end
            end
        end
    end

    // Monitor: check each popped transaction against the oldest owed result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                results_checked++;
                if (owed_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %h/%0d/%0d",
                             $time, result_value, status, last);
                    mismatches++;
                end
                else
                begin
                    want = owed_results[0];
                    owed_results.delete(0);
                    check_field("result_value", want.rv, result_value);
                    check_field("status", {29'd0, want.st}, {29'd0, status});
                    check_field("last", {31'd0, want.lst}, {31'd0, last});
                end
            end
            pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("tb_multiset_table_sorted_drain_top failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int n;
        int r;

        // Directed: empty drain, extremes, duplicates, single-copy removal,
        // an ignored op code, back-to-back drains, and a paused sender.
        queue_cmd(msd_pkg::OP_FINISH, $urandom, 1'b0);
        queue_cmd(msd_pkg::OP_ADD, VAL_MAX, 1'b0);
        queue_cmd(msd_pkg::OP_ADD, VAL_MIN, 1'b0);
        queue_cmd(msd_pkg::OP_ADD, 0, 1'b0);
        queue_cmd(msd_pkg::OP_ADD, -1, 1'b0);
        queue_cmd(msd_pkg::OP_ADD, 5, 1'b0);
        queue_cmd(msd_pkg::OP_ADD, 5, 1'b0);
        queue_cmd(msd_pkg::OP_ADD, 1, 1'b0);
        queue_cmd(msd_pkg::OP_REMOVE, 5, 1'b0);
        queue_cmd(msd_pkg::OP_REMOVE, VAL_MIN, 1'b0);
        queue_cmd(OP_UNUSED, $urandom, 1'b0);
        queue_cmd(msd_pkg::OP_FINISH, $urandom, 1'b0);
        queue_cmd(msd_pkg::OP_FINISH, $urandom, 1'b0);
        queue_cmd(msd_pkg::OP_ADD, int'(32'h5555_5555), 1'b1);
        queue_cmd(msd_pkg::OP_ADD, int'(32'haaaa_aaaa), 1'b0);
        queue_cmd(msd_pkg::OP_ADD, VAL_MAX, 1'b0);
        queue_cmd(msd_pkg::OP_REMOVE, int'(32'haaaa_aaaa), 1'b0);
        queue_cmd(msd_pkg::OP_ADD, VAL_MIN, 1'b0);
        queue_cmd(msd_pkg::OP_FINISH, 0, 1'b0);

        // Random mix, mostly adds, with removes that hit; twice, fill past capacity.
        n = 0;
        while (n < RANDOM_CMDS)
        begin
            if (n == 120 || n == 300)
            begin
                repeat (msd_pkg::CAPACITY - gen_pool.size() + 2)
                begin
                    queue_cmd(msd_pkg::OP_ADD, pick_value(), 1'b0);
                    n++;
                end
                queue_cmd(msd_pkg::OP_FINISH, $urandom, 1'b0);
                n++;
            end
            r = $urandom_range(0, 99);
            if (r < 50 || (r < 80 && gen_pool.size() == 0))
                queue_cmd(msd_pkg::OP_ADD, pick_value(), n == 210);
            else if (r < 80)
                queue_cmd(msd_pkg::OP_REMOVE,
                          gen_pool[$urandom_range(0, gen_pool.size() - 1)], n == 210);
            else if (r < 95)
                queue_cmd(msd_pkg::OP_FINISH, $urandom, n == 210);
            else
            begin
                queue_cmd(OP_UNUSED, $urandom, 1'b0);
                n--;
            end
            n++;
        end

        // Close with a drain and a remove that misses, then every op code while halted.
        queue_cmd(msd_pkg::OP_FINISH, $urandom, 1'b0);
        queue_cmd(msd_pkg::OP_REMOVE, VAL_MAX, 1'b0);
        queue_cmd(msd_pkg::OP_ADD, pick_value(), 1'b0);
        queue_cmd(msd_pkg::OP_REMOVE, pick_value(), 1'b0);
        queue_cmd(msd_pkg::OP_FINISH, $urandom, 1'b0);
        queue_cmd(OP_UNUSED, $urandom, 1'b0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: wait for every command to go out and every owed result to land,
        // then give the block time to show any stray result.
        while (command_q.size() != 0 || push)
            @(posedge clk);
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Covered %0d commands (%0d adds, %0d removes, %0d drains, %0d full drops)",
                 cmds_accepted, adds_seen, removes_seen, finishes_seen, full_drops);
        $display("and checked %0d results, %0d of them after the halt.",
                 results_checked, halted_replies);
        if (mismatches == 0)
            $display("tb_multiset_table_sorted_drain_top passed");
        else
            $display("tb_multiset_table_sorted_drain_top failed");
        $finish;
    end

endmodule
